// File: rtl/core/mh2_pkg.sv
// Shared types, constants and a helper function for the MurmurHash2 stream block.
package mh2_pkg;

   // Mixing constants of the 32-bit MurmurHash2 scheme.
   localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
   localparam int unsigned BODY_SHIFT  = 24;
   localparam int unsigned FIN_SHIFT_A = 13;
   localparam int unsigned FIN_SHIFT_B = 15;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_K_MUL1,
      ST_K_MUL2,
      ST_H_MUL,
      ST_H_MIX,
      ST_F_MUL,
      ST_F_OUT
   } state_type;

   // Operand that the shared multiplier takes in a given cycle.
   typedef enum logic [1:0] {
      OP_KEY,
      OP_KEY_SHIFT,
      OP_HASH,
      OP_FIN
   } op_sel_type;

   // Kind of an incoming beat, from its byte count.
   typedef enum logic [1:0] {
      CLS_ZERO,
      CLS_TAIL,
      CLS_BODY
   } item_class_type;

   // Control bundle from the sequencer to the datapath.
   typedef struct packed {
      logic       ready;
      op_sel_type op_sel;
      logic       key_load;
      logic       mix_load;
      logic       rsp_load;
   } ctrl_type;

   // Byte mask for a tail beat that holds one to three bytes.
   function automatic logic [31:0] tail_mask(input logic [1:0] count);
      logic [31:0] mask;
      begin
         case (count)
            2'd1:    mask = 32'h0000_00ff;
            2'd2:    mask = 32'h0000_ffff;
            2'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'h0000_0000;
         endcase
         return mask;
      end
   endfunction

endpackage

// File: rtl/core/mh2_mul.sv
// Shared multiply-by-constant unit with its operand select and registered product.
module mh2_mul
   import mh2_pkg::*;
(
   input  logic        clock,
   input  op_sel_type  op_sel,
   input  logic [31:0] key,
   input  logic [31:0] hash,
   output logic [31:0] product
);

   logic [31:0] operand;
   logic [31:0] product_ff;
   logic [31:0] product_in;

   // Pick the operand for this step of the sequence.
   always_comb begin
      case (op_sel)
         OP_KEY:       operand = key;
         OP_KEY_SHIFT: operand = product_ff ^ (product_ff >> BODY_SHIFT);
         OP_HASH:      operand = hash;
         OP_FIN:       operand = hash ^ (hash >> FIN_SHIFT_A);
         default:      operand = key;
      endcase
   end

   // Product modulo two to the 32nd.
   assign product_in = operand * MIX_MUL;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// File: rtl/core/mh2_ctrl.sv
// Sequencer that steps the shared multiplier through body, tail and final mixing.
module mh2_ctrl
   import mh2_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_accept,
   input  item_class_type req_class,
   input  logic           req_last,
   input  logic           rsp_free,
   output ctrl_type       ctrl
);

   state_type state_ff;
   state_type state_in;
   logic      last_ff;
   logic      last_in;
   logic      body_ff;
   logic      body_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_class)
                  CLS_BODY: state_in = ST_K_MUL1;
                  CLS_TAIL: state_in = ST_H_MUL;
                  default:  state_in = req_last ? ST_F_MUL : ST_IDLE;
               endcase
            end
         end
         ST_K_MUL1: state_in = ST_K_MUL2;
         ST_K_MUL2: state_in = ST_H_MUL;
         ST_H_MUL:  state_in = ST_H_MIX;
         ST_H_MIX:  state_in = last_ff ? ST_F_MUL : ST_IDLE;
         ST_F_MUL:  state_in = ST_F_OUT;
         ST_F_OUT:  state_in = rsp_free ? ST_IDLE : ST_F_OUT;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Item flags are captured with the beat and held through its sequence.
   assign last_in = (req_accept) ? req_last : last_ff;
   assign body_in = (req_accept) ? (req_class == CLS_BODY) : body_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
         body_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         body_ff  <= body_in;
      end
   end

   // Control outputs.
   always_comb begin
      ctrl.ready    = (state_ff == ST_IDLE);
      ctrl.op_sel   = OP_KEY;
      ctrl.key_load = 1'b0;
      ctrl.mix_load = 1'b0;
      ctrl.rsp_load = 1'b0;
      case (state_ff)
         ST_K_MUL1: ctrl.op_sel = OP_KEY;
         ST_K_MUL2: ctrl.op_sel = OP_KEY_SHIFT;
         ST_H_MUL: begin
            ctrl.op_sel   = OP_HASH;
            ctrl.key_load = body_ff;
         end
         ST_H_MIX:  ctrl.mix_load = 1'b1;
         ST_F_MUL:  ctrl.op_sel = OP_FIN;
         // The hash is unchanged here, so the final product holds while the result waits.
         ST_F_OUT: begin
            ctrl.op_sel   = OP_FIN;
            ctrl.rsp_load = rsp_free;
         end
         default:   ctrl.op_sel = OP_KEY;
      endcase
   end

endmodule

// File: rtl/core/murmur2_hash32_stream.sv
// Top level of the streaming 32-bit MurmurHash2 engine.
//
//   Channel   Direction  Handshake          Beat contents
//   req_      in         req_valid/stall    key word, byte count, first, last, length
//   rsp_      out        rsp_valid/stall    finalized 32-bit hash
//   csr_      in         csr_valid/ready    hash seed
//
// A four-byte beat steps through two key multiplies, a hash multiply and a mix step, a tail
// beat through the hash multiply and mix step and an empty beat through none, all on the one
// shared 32x32 multiplier that each mixing step goes through.
// A last beat adds the final avalanche on the same multiplier.
// Synchronous reset clears the sequencer, the running hash, the seed and the result flag.
// A stalled result waits in its output register; new beats are taken meanwhile,
// but a next final result waits until the earlier one has been taken.
module murmur2_hash32_stream
   import mh2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_word_data,
   input  logic [2:0]  req_byte_count,
   input  logic        req_first_word,
   input  logic        req_last_word,
   input  logic [15:0] req_key_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_hash_seed
);

   ctrl_type       ctrl;
   item_class_type req_class;
   logic           req_accept;
   logic           rsp_free;
   logic [31:0]    product;
   logic [31:0]    start_hash;
   logic [31:0]    seed_ff;
   logic [31:0]    seed_in;
   logic [31:0]    hash_ff;
   logic [31:0]    hash_in;
   logic [31:0]    key_ff;
   logic [31:0]    key_in;
   logic [31:0]    rsp_hash_ff;
   logic [31:0]    rsp_hash_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   // Handshakes.
   assign req_stall  = !ctrl.ready;
   assign req_accept = req_valid && ctrl.ready;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // Classify the beat; counts above four count as a full word.
   always_comb begin
      if (req_byte_count[2]) begin
         req_class = CLS_BODY;
      end else if (req_byte_count[1:0] != 2'd0) begin
         req_class = CLS_TAIL;
      end else begin
         req_class = CLS_ZERO;
      end
   end

   mh2_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_class  (req_class),
      .req_last   (req_last_word),
      .rsp_free   (rsp_free),
      .ctrl       (ctrl)
   );

   mh2_mul u_mul (
      .clock   (clock),
      .op_sel  (ctrl.op_sel),
      .key     (key_ff),
      .hash    (hash_ff),
      .product (product)
   );

   // Seed register.
   assign seed_in = (csr_valid) ? csr_hash_seed : seed_ff;

   // Running hash and key word.
   assign start_hash = (req_first_word) ? (seed_ff ^ {16'h0000, req_key_length}) : hash_ff;

   always_comb begin
      hash_in = hash_ff;
      key_in  = key_ff;
      if (req_accept) begin
         case (req_class)
            CLS_BODY: begin
               hash_in = start_hash;
               key_in  = req_word_data;
            end
            CLS_TAIL: begin
               hash_in = start_hash ^ (req_word_data & tail_mask(req_byte_count[1:0]));
               key_in  = 32'h0000_0000;
            end
            default: begin
               hash_in = start_hash;
            end
         endcase
      end else if (ctrl.key_load) begin
         key_in = product;
      end else if (ctrl.mix_load) begin
         hash_in = product ^ key_ff;
      end
   end

   // Result register.
   assign rsp_hash_in  = (ctrl.rsp_load) ? (product ^ (product >> FIN_SHIFT_B)) : rsp_hash_ff;
   assign rsp_valid_in = ctrl.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= 32'h0000_0000;
         hash_ff      <= 32'h0000_0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

// File: rtl/core/mh2_checker.sv
// Port-level checker for the MurmurHash2 stream block and its bind.
module mh2_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_byte_count,
   input logic        req_last_word,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_hash_value
);

   // A stalled result beat holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result beat changed while stalled");

   // Reset leaves the block ready with no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // A beat with bytes, or a last beat, keeps the multiplier busy.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_byte_count != 3'd0 || req_last_word) |=> req_stall)
      else $error("input taken while the previous beat is still in work");

   // A full body beat, not last, stalls through K_MUL1 to H_MIX.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_byte_count[2] && !req_last_word |->
         ##1 req_stall ##1 req_stall ##1 req_stall ##1 req_stall ##1 !req_stall)
      else $error("body beat sequence length is wrong");

endmodule

bind murmur2_hash32_stream mh2_checker u_mh2_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_byte_count (req_byte_count),
   .req_last_word  (req_last_word),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hash_value (rsp_hash_value)
);
